@@ sv/jles_pkg.sv @@
// ----------------------------------------------------------------------------
// jles_pkg: shared types and constants of the emergency stop ramp unit
// Command record, field widths, register and action codes, and saturation.
// ----------------------------------------------------------------------------
package jles_pkg;

  // Width of every command quantity and of the time stamp.
  localparam int DATA_W = 32;

  // Stored widths of the two configuration registers.
  localparam int TARGET_W = 22;
  localparam int JERK_W   = 21;

  // Configuration port: 32-bit data, registers at byte addresses 0 and 4.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Word index of each configuration register (byte address bit 2).
  localparam logic REG_TARGET_ACCEL = 1'b0;
  localparam logic REG_RAMP_JERK    = 1'b1;

  // Action codes; the two remaining codes both mean a tick.
  localparam logic [1:0] ACT_STOP_OFF = 2'd0;
  localparam logic [1:0] ACT_STOP_ON  = 2'd1;

  // One longitudinal command.
  typedef struct packed {
    logic        [DATA_W-1:0] stamp;
    logic signed [DATA_W-1:0] velocity;
    logic signed [DATA_W-1:0] accel;
    logic signed [DATA_W-1:0] jerk;
  } cmd_t;

  // Clamp a wide signed sum into the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [64:0] x);
    logic fits;
    begin
      fits = (x[64:DATA_W-1] == '0) || (x[64:DATA_W-1] == '1);
      if (fits) begin
        sat32 = x[DATA_W-1:0];
      end else if (x[64]) begin
        sat32 = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        sat32 = {1'b0, {(DATA_W-1){1'b1}}};
      end
    end
  endfunction

endpackage

@@ sv/jerk_limited_emergency_stop_ramp_unit.sv @@
// ----------------------------------------------------------------------------
// jerk_limited_emergency_stop_ramp_unit: jerk-limited emergency stop ramp
// Mode requests and ticks in, one command item out for each item taken.
// ----------------------------------------------------------------------------
// Flow: an item is registered on acceptance and moves to the result register
// once that register is empty or being emptied, where its result is offered.
// Throughput: one item per cycle while results are taken; the input and result
// registers hand over in the same cycle; a tick also updates the last command.
// Reset (rst_n low at a rising edge): both channels empty, stop mode off,
// last command zero, registers back to -2.5 and -1.5 in the fixed-point scale.
module jerk_limited_emergency_stop_ramp_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input items.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // now_time [31:0], cmd_stamp [63:32], cmd_velocity [95:64],
  // cmd_accel [127:96], cmd_jerk [159:128]
  input  logic [159:0]                        in_tdata,
  // action [1:0], cmd_valid [2]
  input  logic [2:0]                          in_tuser,
  // Result items.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_stamp [31:0], out_velocity [63:32], out_accel [95:64],
  // out_jerk [127:96]
  output logic [127:0]                        out_tdata,
  // operating [0], request_ok [1]
  output logic [1:0]                          out_tuser,
  // Configuration port.
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [jles_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [jles_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [jles_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  localparam int TW = jles_pkg::TARGET_W;
  localparam int JW = jles_pkg::JERK_W;

  // Defaults -2.5 and -1.5, truncated to the register widths.
  localparam int TARGET_RST_I = -5 * (1 << (FRAC_BITS - 1));
  localparam int JERK_RST_I   = -3 * (1 << (FRAC_BITS - 1));
  localparam logic [TW-1:0] TARGET_RST = TARGET_RST_I[TW-1:0];
  localparam logic [JW-1:0] JERK_RST   = JERK_RST_I[JW-1:0];

  // Configuration registers.
  logic signed [TW-1:0] target_r;
  logic signed [JW-1:0] jerk_r;
  logic                 cfg_wr;
  logic                 cfg_sel;

  // Input register stage.
  logic                              s1_valid_r;
  logic [1:0]                        s1_act_r;
  logic                              s1_cmd_valid_r;
  logic [jles_pkg::DATA_W-1:0]       s1_now_r;
  jles_pkg::cmd_t                    s1_cmd_r;

  // Stored state: stop mode and the last emitted command.
  logic                              mode_r;
  logic                              mode_nxt;
  jles_pkg::cmd_t                    last_r;

  // Result register stage.
  logic                              out_valid_r;
  logic                              out_valid_nxt;
  jles_pkg::cmd_t                    out_cmd_r;
  logic                              out_oper_r;
  logic                              out_ack_r;

  logic                              advance;
  logic                              is_req;
  jles_pkg::cmd_t                    ramp_cmd;
  jles_pkg::cmd_t                    res_cmd;

  // ---------------------------------------------------------------------
  // Configuration. The low two address bits select byte lanes and are
  // ignored; bit 2 picks the register. Reads return the sign-extended value.
  // ---------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RST;
      jerk_r   <= JERK_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        jles_pkg::REG_TARGET_ACCEL: target_r <= cfg_pwdata[TW-1:0];
        jles_pkg::REG_RAMP_JERK:    jerk_r   <= cfg_pwdata[JW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      jles_pkg::REG_TARGET_ACCEL: cfg_prdata = 32'(target_r);
      jles_pkg::REG_RAMP_JERK:    cfg_prdata = 32'(jerk_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake. The input register moves into the result register whenever
  // the result register is empty or being emptied. While a finished result
  // waits, the input side takes an item only if the input register is empty.
  // ---------------------------------------------------------------------
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_act_r          <= in_tuser[1:0];
      s1_cmd_valid_r    <= in_tuser[2];
      s1_now_r          <= in_tdata[31:0];
      s1_cmd_r.stamp    <= in_tdata[63:32];
      s1_cmd_r.velocity <= in_tdata[95:64];
      s1_cmd_r.accel    <= in_tdata[127:96];
      s1_cmd_r.jerk     <= in_tdata[159:128];
    end
  end

  // ---------------------------------------------------------------------
  // Single pass. A mode request only switches the flag and returns a zero
  // command. A tick in stop mode extrapolates the last command; otherwise
  // the upstream command passes through, or a zero command stamped now
  // when none is present. Because state is written on the same edge that
  // loads the result, the next item in the input register already sees it.
  // ---------------------------------------------------------------------
  jles_extrap #(
    .FRAC_BITS (FRAC_BITS)
  ) u_extrap (
    .last_cmd     (last_r),
    .now_time     (s1_now_r),
    .target_accel (target_r),
    .ramp_jerk    (jerk_r),
    .ramp_cmd     (ramp_cmd)
  );

  assign is_req   = (s1_act_r == jles_pkg::ACT_STOP_OFF) ||
                    (s1_act_r == jles_pkg::ACT_STOP_ON);
  assign mode_nxt = is_req ? (s1_act_r == jles_pkg::ACT_STOP_ON) : mode_r;

  always_comb begin
    res_cmd = '0;
    if (is_req) begin
      res_cmd = '0;
    end else if (mode_r) begin
      res_cmd = ramp_cmd;
    end else if (s1_cmd_valid_r) begin
      res_cmd = s1_cmd_r;
    end else begin
      res_cmd.stamp = s1_now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      last_r <= '0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      if (!is_req) begin
        last_r <= res_cmd;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------
  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_cmd_r  <= res_cmd;
      out_oper_r <= mode_nxt;
      out_ack_r  <= is_req;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cmd_r.jerk, out_cmd_r.accel, out_cmd_r.velocity, out_cmd_r.stamp};
  assign out_tuser  = {out_ack_r, out_oper_r};

endmodule

@@ sv/jles_extrap.sv @@
// ----------------------------------------------------------------------------
// jles_extrap: ramp extrapolation of the last command
// Advances the stored command over the elapsed time towards a stop.
// ----------------------------------------------------------------------------
module jles_extrap #(
  parameter int FRAC_BITS = 16
) (
  input  jles_pkg::cmd_t                            last_cmd,
  input  logic [jles_pkg::DATA_W-1:0]               now_time,
  input  logic signed [jles_pkg::TARGET_W-1:0]      target_accel,
  input  logic signed [jles_pkg::JERK_W-1:0]        ramp_jerk,
  output jles_pkg::cmd_t                            ramp_cmd
);

  logic        [jles_pkg::DATA_W-1:0] dt;
  logic signed [jles_pkg::DATA_W:0]   dt_s;
  logic signed [64:0]                 prod_v;
  logic signed [64:0]                 prod_a;
  logic signed [64:0]                 sum_v;
  logic signed [64:0]                 sum_a;
  logic signed [jles_pkg::DATA_W-1:0] vel_sat;
  logic signed [jles_pkg::DATA_W-1:0] acc_sat;
  logic signed [jles_pkg::DATA_W-1:0] target_ext;
  logic signed [jles_pkg::DATA_W-1:0] jerk_ext;

  // Elapsed time wraps modulo 2^32 and is always read as unsigned.
  assign dt   = now_time - last_cmd.stamp;
  assign dt_s = $signed({1'b0, dt});

  assign target_ext = 32'(target_accel);
  assign jerk_ext   = 32'(ramp_jerk);

  assign prod_v = 65'(last_cmd.accel) * 65'(dt_s);
  assign prod_a = 65'(ramp_jerk) * 65'(dt_s);

  // The arithmetic shift floors the products towards minus infinity.
  assign sum_v = (prod_v >>> FRAC_BITS) + 65'(last_cmd.velocity);
  assign sum_a = (prod_a >>> FRAC_BITS) + 65'(last_cmd.accel);

  assign vel_sat = jles_pkg::sat32(sum_v);
  assign acc_sat = jles_pkg::sat32(sum_a);

  always_comb begin
    ramp_cmd.stamp    = now_time;
    ramp_cmd.velocity = vel_sat[jles_pkg::DATA_W-1] ? '0 : vel_sat;
    ramp_cmd.accel    = (acc_sat < target_ext) ? target_ext : acc_sat;
    ramp_cmd.jerk     = (last_cmd.accel == target_ext) ? '0 : jerk_ext;
  end

endmodule

@@ sv/jles_checker.sv @@
// ----------------------------------------------------------------------------
// jles_checker: port-level checks of the emergency stop ramp unit
// Watches the item channels and flags results that break the block's rules.
// ----------------------------------------------------------------------------
module jles_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic [1:0]   out_tuser
);

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // Reset empties the result channel.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  // With no result waiting, the block always takes a new item.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result register");

  // An acknowledged mode request carries a zero command.
  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0)
    else $error("mode acknowledgement with a non-zero command");

  // A tick in stop mode never commands a negative velocity.
  a_ramp_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] && out_tuser[0] |-> !out_tdata[63])
    else $error("negative velocity while ramping");

endmodule

bind jerk_limited_emergency_stop_ramp_unit jles_checker u_jles_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
